// ===== rtl/jcfp_pkg.sv =====
// Shared types, constants and keyword tables of the JSON command frame parser.
package jcfp_pkg;

  // Default sizing and the reset value of the line limit register.
  localparam int LineCountBitsDef = 12;
  localparam int QueueDepthDef    = 2;
  localparam int MaxLineW         = 12;
  localparam int LineLenW         = 12;
  localparam logic [MaxLineW-1:0] MaxLineReset = 12'd511;

  // Keyword lengths.
  localparam logic [3:0] KwCommandLen = 4'd7;
  localparam logic [3:0] KwLineLen    = 4'd4;
  localparam logic [3:0] KwSendLen    = 4'd4;
  localparam logic [3:0] KwCapsLen    = 4'd12;

  // Character codes used by the classifier.
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;

  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_PLAIN = 2'd1,
    KIND_CMD   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_CAPS = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ERR_COMMA   = 4'd0,
    ERR_NAME    = 4'd1,
    ERR_COLON   = 4'd2,
    ERR_VALUE   = 4'd3,
    ERR_KEY     = 4'd4,
    ERR_TRAIL   = 4'd5,
    ERR_LENGTH  = 4'd6,
    ERR_COMMAND = 4'd7,
    ERR_CAPLINE = 4'd8,
    ERR_NONE    = 4'd15
  } err_e;

  typedef enum logic [9:0] {
    PH_START  = 10'b00_0000_0001,
    PH_OBJ    = 10'b00_0000_0010,
    PH_COMMA  = 10'b00_0000_0100,
    PH_KEY    = 10'b00_0000_1000,
    PH_COLON  = 10'b00_0001_0000,
    PH_PREVAL = 10'b00_0010_0000,
    PH_VAL    = 10'b00_0100_0000,
    PH_TAIL   = 10'b00_1000_0000,
    PH_PLAIN  = 10'b01_0000_0000,
    PH_ERROR  = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_CMD  = 2'd1,
    TGT_LINE = 2'd2
  } target_e;

  // One classified input word as it travels from the front to the back.
  typedef struct packed {
    logic       eot;
    logic       blank;
    logic       lbrace;
    logic       rbrace;
    logic       quote;
    logic       comma;
    logic       colon;
    logic       bslash;
    logic       ctrl;
    logic       esc_ok;
    logic [7:0] esc_byte;
    logic [7:0] raw;
  } item_t;

  // One result word.
  typedef struct packed {
    kind_e                kind;
    logic [7:0]           line_byte;
    cmd_e                 cmd;
    logic [3:0]           err_code;
    logic [LineLenW-1:0]  line_length;
  } result_t;

  // Keyword character tables; positions past the end return zero.
  function automatic logic [7:0] kw_command_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "c";
      4'd1: c = "o";
      4'd2: c = "m";
      4'd3: c = "m";
      4'd4: c = "a";
      4'd5: c = "n";
      4'd6: c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_line_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "l";
      4'd1: c = "i";
      4'd2: c = "n";
      4'd3: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_send_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "s";
      4'd1: c = "e";
      4'd2: c = "n";
      4'd3: c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_caps_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:  c = "c";
      4'd1:  c = "a";
      4'd2:  c = "p";
      4'd3:  c = "a";
      4'd4:  c = "b";
      4'd5:  c = "i";
      4'd6:  c = "l";
      4'd7:  c = "i";
      4'd8:  c = "t";
      4'd9:  c = "i";
      4'd10: c = "e";
      4'd11: c = "s";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/jcfp_fifo.sv =====
// Small register queue used between the parser stages and at the result side.
module jcfp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 2) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage needs no reset; an entry is only read after it was written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/jcfp_front.sv =====
// Front stage: classifies each raw input word into token flags and escape decode.
module jcfp_front (
  input  logic             text_byte_i,
  input  logic [7:0]       raw_i,
  input  logic             eot_i,
  output jcfp_pkg::item_t  item_o
);

  logic [7:0] esc_byte;
  logic       esc_ok;

  // Escape decode for the byte after a backslash.
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = raw_i;
    case (raw_i)
      jcfp_pkg::ChQuote:  esc_byte = jcfp_pkg::ChQuote;
      jcfp_pkg::ChBslash: esc_byte = jcfp_pkg::ChBslash;
      jcfp_pkg::ChSlash:  esc_byte = jcfp_pkg::ChSlash;
      "b":                esc_byte = 8'h08;
      "f":                esc_byte = 8'h0C;
      "n":                esc_byte = 8'h0A;
      "r":                esc_byte = 8'h0D;
      "t":                esc_byte = 8'h09;
      default: begin
        esc_ok   = 1'b0;
        esc_byte = 8'h00;
      end
    endcase
  end

  // Token flags; a valid word qualifies nothing here, the queue does that.
  always_comb begin
    item_o.eot      = eot_i && text_byte_i;
    item_o.blank    = (raw_i == jcfp_pkg::ChSpace) ||
                      (raw_i >= jcfp_pkg::ChTab && raw_i <= jcfp_pkg::ChCr);
    item_o.lbrace   = (raw_i == jcfp_pkg::ChLbrace);
    item_o.rbrace   = (raw_i == jcfp_pkg::ChRbrace);
    item_o.quote    = (raw_i == jcfp_pkg::ChQuote);
    item_o.comma    = (raw_i == jcfp_pkg::ChComma);
    item_o.colon    = (raw_i == jcfp_pkg::ChColon);
    item_o.bslash   = (raw_i == jcfp_pkg::ChBslash);
    item_o.ctrl     = (raw_i < jcfp_pkg::ChSpace);
    item_o.esc_ok   = esc_ok;
    item_o.esc_byte = esc_byte;
    item_o.raw      = raw_i;
  end

endmodule

// ===== rtl/jcfp_back.sv =====
// Back stage: the object parser state machine, line counting and the final verdict.
module jcfp_back #(
  parameter int LineCountBits = jcfp_pkg::LineCountBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [jcfp_pkg::MaxLineW-1:0]   max_line_i,
  input  logic                            in_valid_i,
  input  jcfp_pkg::item_t                 item_i,
  output logic                            in_pop_o,
  input  logic                            out_full_i,
  output logic                            out_push_o,
  output jcfp_pkg::result_t               result_o
);

  localparam int CmpW = (LineCountBits > jcfp_pkg::MaxLineW) ? LineCountBits
                                                             : jcfp_pkg::MaxLineW;

  jcfp_pkg::phase_e            phase_q, phase_d;
  jcfp_pkg::target_e           tgt_q, tgt_d;
  jcfp_pkg::err_e              err_q, err_d;
  logic                        first_q, first_d;
  logic                        esc_q, esc_d;
  logic [3:0]                  kmi_q, kmi_d;
  logic [1:0]                  kc_q, kc_d;
  logic                        seen_cmd_q, seen_cmd_d;
  logic                        seen_line_q, seen_line_d;
  logic [3:0]                  cmi_q, cmi_d;
  logic [1:0]                  cv_q, cv_d;
  logic [LineCountBits-1:0]    cnt_q, cnt_d;
  logic                        long_q, long_d;

  logic                        go;
  logic                        have, str_err, str_close, str_esc;
  logic [7:0]                  dec;
  logic [CmpW-1:0]             cnt_ext, max_ext;
  logic                        is_send, is_caps, k_cmd, k_line;

  assign in_pop_o = in_valid_i && !out_full_i;
  assign go       = in_pop_o;
  assign cnt_ext  = CmpW'(cnt_q);
  assign max_ext  = CmpW'(max_line_i);
  assign is_send  = seen_cmd_q && cv_q[0] && (cmi_q == jcfp_pkg::KwSendLen);
  assign is_caps  = seen_cmd_q && cv_q[1] && (cmi_q == jcfp_pkg::KwCapsLen);
  assign k_cmd    = kc_q[0] && (kmi_q == jcfp_pkg::KwCommandLen);
  assign k_line   = kc_q[1] && (kmi_q == jcfp_pkg::KwLineLen);

  // String body decode shared by key and value strings.
  always_comb begin
    have      = 1'b0;
    str_err   = 1'b0;
    str_close = 1'b0;
    str_esc   = 1'b0;
    dec       = item_i.raw;
    if (esc_q) begin
      if (item_i.esc_ok) begin
        have = 1'b1;
        dec  = item_i.esc_byte;
      end else begin
        str_err = 1'b1;
      end
    end else if (item_i.quote) begin
      str_close = 1'b1;
    end else if (item_i.ctrl) begin
      str_err = 1'b1;
    end else if (item_i.bslash) begin
      str_esc = 1'b1;
    end else begin
      have = 1'b1;
    end
  end

  // Parser next state and result formation.
  always_comb begin
    phase_d     = phase_q;
    tgt_d       = tgt_q;
    err_d       = err_q;
    first_d     = first_q;
    esc_d       = esc_q;
    kmi_d       = kmi_q;
    kc_d        = kc_q;
    seen_cmd_d  = seen_cmd_q;
    seen_line_d = seen_line_q;
    cmi_d       = cmi_q;
    cv_d        = cv_q;
    cnt_d       = cnt_q;
    long_d      = long_q;
    out_push_o  = 1'b0;
    result_o    = '0;

    if (go && item_i.eot) begin
      // Verdict, then back to the reset state.
      out_push_o    = 1'b1;
      result_o.kind = jcfp_pkg::KIND_ERROR;
      unique case (phase_q)
        jcfp_pkg::PH_START, jcfp_pkg::PH_PLAIN: result_o.kind = jcfp_pkg::KIND_PLAIN;
        jcfp_pkg::PH_ERROR:  result_o.err_code = err_q;
        jcfp_pkg::PH_OBJ:    result_o.err_code = first_q ? jcfp_pkg::ERR_NAME
                                                         : jcfp_pkg::ERR_COMMA;
        jcfp_pkg::PH_COMMA, jcfp_pkg::PH_KEY: result_o.err_code = jcfp_pkg::ERR_NAME;
        jcfp_pkg::PH_COLON:  result_o.err_code = jcfp_pkg::ERR_COLON;
        jcfp_pkg::PH_PREVAL, jcfp_pkg::PH_VAL: result_o.err_code = jcfp_pkg::ERR_VALUE;
        default: begin
          if (is_send) begin
            if (!seen_line_q || cnt_q == '0 || long_q || cnt_ext > max_ext) begin
              result_o.err_code = jcfp_pkg::ERR_LENGTH;
            end else begin
              result_o.kind        = jcfp_pkg::KIND_CMD;
              result_o.cmd         = jcfp_pkg::CMD_SEND;
              result_o.line_length = cnt_ext[jcfp_pkg::LineLenW-1:0];
            end
          end else if (!is_caps) begin
            result_o.err_code = jcfp_pkg::ERR_COMMAND;
          end else if (seen_line_q) begin
            result_o.err_code = jcfp_pkg::ERR_CAPLINE;
          end else begin
            result_o.kind = jcfp_pkg::KIND_CMD;
            result_o.cmd  = jcfp_pkg::CMD_CAPS;
          end
        end
      endcase
      phase_d     = jcfp_pkg::PH_START;
      tgt_d       = jcfp_pkg::TGT_NONE;
      err_d       = jcfp_pkg::ERR_NONE;
      first_d     = 1'b1;
      esc_d       = 1'b0;
      kmi_d       = '0;
      kc_d        = 2'b11;
      seen_cmd_d  = 1'b0;
      seen_line_d = 1'b0;
      cmi_d       = '0;
      cv_d        = 2'b11;
      cnt_d       = '0;
      long_d      = 1'b0;
    end else if (go) begin
      unique case (phase_q)
        jcfp_pkg::PH_START: begin
          if (!item_i.blank) begin
            phase_d = item_i.lbrace ? jcfp_pkg::PH_OBJ : jcfp_pkg::PH_PLAIN;
          end
        end
        jcfp_pkg::PH_OBJ: begin
          if (!item_i.blank) begin
            if (item_i.rbrace) begin
              phase_d = jcfp_pkg::PH_TAIL;
            end else if (first_q) begin
              if (item_i.quote) begin
                first_d = 1'b0;
                kmi_d   = '0;
                kc_d    = 2'b11;
                phase_d = jcfp_pkg::PH_KEY;
              end else begin
                err_d   = jcfp_pkg::ERR_NAME;
                phase_d = jcfp_pkg::PH_ERROR;
              end
            end else if (item_i.comma) begin
              phase_d = jcfp_pkg::PH_COMMA;
            end else begin
              err_d   = jcfp_pkg::ERR_COMMA;
              phase_d = jcfp_pkg::PH_ERROR;
            end
          end
        end
        jcfp_pkg::PH_COMMA: begin
          if (!item_i.blank) begin
            if (item_i.quote) begin
              kmi_d   = '0;
              kc_d    = 2'b11;
              phase_d = jcfp_pkg::PH_KEY;
            end else begin
              err_d   = jcfp_pkg::ERR_NAME;
              phase_d = jcfp_pkg::PH_ERROR;
            end
          end
        end
        jcfp_pkg::PH_KEY: begin
          esc_d = str_esc;
          if (str_err) begin
            err_d   = jcfp_pkg::ERR_NAME;
            phase_d = jcfp_pkg::PH_ERROR;
          end else if (str_close) begin
            phase_d = jcfp_pkg::PH_COLON;
          end else if (have) begin
            // Narrow the key candidates by one character.
            if (!(kmi_q < jcfp_pkg::KwCommandLen &&
                  dec == jcfp_pkg::kw_command_char(kmi_q))) begin
              kc_d[0] = 1'b0;
            end
            if (!(kmi_q < jcfp_pkg::KwLineLen &&
                  dec == jcfp_pkg::kw_line_char(kmi_q))) begin
              kc_d[1] = 1'b0;
            end
            if (kmi_q != 4'hF) begin
              kmi_d = kmi_q + 1'b1;
            end
          end
        end
        jcfp_pkg::PH_COLON: begin
          if (!item_i.blank) begin
            if (item_i.colon) begin
              phase_d = jcfp_pkg::PH_PREVAL;
            end else begin
              err_d   = jcfp_pkg::ERR_COLON;
              phase_d = jcfp_pkg::PH_ERROR;
            end
          end
        end
        jcfp_pkg::PH_PREVAL: begin
          if (!item_i.blank) begin
            if (item_i.quote) begin
              if (k_cmd && !seen_cmd_q) begin
                tgt_d = jcfp_pkg::TGT_CMD;
              end else if (k_line && !seen_line_q) begin
                tgt_d = jcfp_pkg::TGT_LINE;
              end else begin
                tgt_d = jcfp_pkg::TGT_NONE;
              end
              phase_d = jcfp_pkg::PH_VAL;
            end else begin
              err_d   = jcfp_pkg::ERR_VALUE;
              phase_d = jcfp_pkg::PH_ERROR;
            end
          end
        end
        jcfp_pkg::PH_VAL: begin
          esc_d = str_esc;
          if (str_err) begin
            err_d   = jcfp_pkg::ERR_VALUE;
            phase_d = jcfp_pkg::PH_ERROR;
          end else if (str_close) begin
            // An unknown or repeated key is reported once its value closes.
            if (tgt_q == jcfp_pkg::TGT_CMD) begin
              seen_cmd_d = 1'b1;
            end
            if (tgt_q == jcfp_pkg::TGT_LINE) begin
              seen_line_d = 1'b1;
            end
            if (tgt_q == jcfp_pkg::TGT_NONE) begin
              err_d   = jcfp_pkg::ERR_KEY;
              phase_d = jcfp_pkg::PH_ERROR;
            end else begin
              phase_d = jcfp_pkg::PH_OBJ;
            end
            tgt_d = jcfp_pkg::TGT_NONE;
          end else if (have) begin
            if (tgt_q == jcfp_pkg::TGT_CMD) begin
              if (!(cmi_q < jcfp_pkg::KwSendLen &&
                    dec == jcfp_pkg::kw_send_char(cmi_q))) begin
                cv_d[0] = 1'b0;
              end
              if (!(cmi_q < jcfp_pkg::KwCapsLen &&
                    dec == jcfp_pkg::kw_caps_char(cmi_q))) begin
                cv_d[1] = 1'b0;
              end
              if (cmi_q != 4'hF) begin
                cmi_d = cmi_q + 1'b1;
              end
            end else if (tgt_q == jcfp_pkg::TGT_LINE) begin
              // Count the line byte, saturating, and pass it on.
              if (cnt_ext >= max_ext || (&cnt_q)) begin
                long_d = 1'b1;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
              out_push_o         = 1'b1;
              result_o.kind      = jcfp_pkg::KIND_LINE;
              result_o.line_byte = dec;
            end
          end
        end
        jcfp_pkg::PH_TAIL: begin
          if (!item_i.blank) begin
            err_d   = jcfp_pkg::ERR_TRAIL;
            phase_d = jcfp_pkg::PH_ERROR;
          end
        end
        default: begin
          // Plain text and latched errors ignore bytes until the end word.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= jcfp_pkg::PH_START;
      tgt_q       <= jcfp_pkg::TGT_NONE;
      err_q       <= jcfp_pkg::ERR_NONE;
      first_q     <= 1'b1;
      esc_q       <= 1'b0;
      kmi_q       <= '0;
      kc_q        <= 2'b11;
      seen_cmd_q  <= 1'b0;
      seen_line_q <= 1'b0;
      cmi_q       <= '0;
      cv_q        <= 2'b11;
      cnt_q       <= '0;
      long_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tgt_q       <= tgt_d;
      err_q       <= err_d;
      first_q     <= first_d;
      esc_q       <= esc_d;
      kmi_q       <= kmi_d;
      kc_q        <= kc_d;
      seen_cmd_q  <= seen_cmd_d;
      seen_line_q <= seen_line_d;
      cmi_q       <= cmi_d;
      cv_q        <= cv_d;
      cnt_q       <= cnt_d;
      long_q      <= long_d;
    end
  end

endmodule

// ===== rtl/json_command_frame_parser.sv =====
// Top level of the JSON command frame parser: front classifier, queues, back parser.
//
// The block takes one message byte (or an end marker) per clock and sustains one word
// per cycle in both directions while full is low and the result side pops. An
// input word is registered in the front queue and parsed as it leaves it; the parser
// writes its result word, if it has one, into the result queue, from which it can be
// popped. Each decoded byte of the first "line" value comes out as a line word as it
// is parsed; the end word gives the verdict (plain text, accepted command, or the
// first error) and the parser returns to its reset state. The result queue holds
// QueueDepth words, so the input side keeps accepting while a result waits to be
// popped; once the result queue is full the parser stops, and full rises when the
// front queue also holds QueueDepth words. Nothing needs a clearing pass after reset.
// Write max_line_length only while no message is in flight.
module json_command_frame_parser #(
  parameter int LineCountBits = jcfp_pkg::LineCountBitsDef,
  parameter int QueueDepth    = jcfp_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    text_byte_i,
  input  logic                          end_of_text_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    result_kind_o,
  output logic [7:0]                    line_byte_o,
  output logic                          command_kind_o,
  output logic [3:0]                    error_code_o,
  output logic [jcfp_pkg::LineLenW-1:0] line_length_o,
  input  logic                          max_line_length_we_i,
  input  logic [jcfp_pkg::MaxLineW-1:0] max_line_length_i
);

  localparam int ItemW = $bits(jcfp_pkg::item_t);
  localparam int ResW  = $bits(jcfp_pkg::result_t);

  logic [jcfp_pkg::MaxLineW-1:0] max_line_q;
  jcfp_pkg::item_t               in_item, mid_item;
  jcfp_pkg::result_t             back_res, out_res;
  logic                          mid_empty, mid_pop;
  logic                          out_full, out_push;

  // Line limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= jcfp_pkg::MaxLineReset;
    end else if (max_line_length_we_i) begin
      max_line_q <= max_line_length_i;
    end
  end

  // Front classifier.
  jcfp_front u_front (
    .text_byte_i (1'b1),
    .raw_i       (text_byte_i),
    .eot_i       (end_of_text_i),
    .item_o      (in_item)
  );

  // Queue between the classifier and the parser.
  jcfp_fifo #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .rdata_o (mid_item),
    .empty_o (mid_empty)
  );

  // Parser.
  jcfp_back #(
    .LineCountBits (LineCountBits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_line_i (max_line_q),
    .in_valid_i (!mid_empty),
    .item_i     (mid_item),
    .in_pop_o   (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .result_o   (back_res)
  );

  // Result queue.
  jcfp_fifo #(
    .Width (ResW),
    .Depth (QueueDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign result_kind_o  = out_res.kind;
  assign line_byte_o    = out_res.line_byte;
  assign command_kind_o = out_res.cmd;
  assign error_code_o   = out_res.err_code;
  assign line_length_o  = out_res.line_length;

  // The parser only consumes a word when the result queue has room.
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !out_full) else $error("parser consumed a word with the result queue full");

  // Every end word consumed produces a verdict word.
  a_eot_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_pop && mid_item.eot) |-> (out_push &&
      back_res.kind != jcfp_pkg::KIND_LINE)) else $error("end word without verdict");

  // An error verdict always carries a defined error code.
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == jcfp_pkg::KIND_ERROR) |->
      (error_code_o <= jcfp_pkg::ERR_CAPLINE)) else $error("undefined error code");

  // A capabilities command never reports a line length.
  a_caps_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == jcfp_pkg::KIND_CMD && command_kind_o) |->
      (line_length_o == '0)) else $error("capabilities command with a line length");

endmodule

// ===== dv/json_command_frame_parser_tb.sv =====
// Self-checking testbench of the JSON command frame parser with a scoreboard class.
module json_command_frame_parser_tb;
  import jcfp_pkg::*;

  localparam int    CycleLimit  = 300000;
  localparam int    HoldCycles  = 300;
  localparam string KeyCommand  = "command";
  localparam string KeyLine     = "line";
  localparam string WordSend    = "send";
  localparam string WordCaps    = "capabilities";
  localparam string EscLetters  = "\"\\/bfnrt";

  // Predicts the verdict and line words of each message and checks the popped words.
  class frame_scoreboard;
    logic [MaxLineW-1:0]         line_limit;
    phase_e                      phase;
    bit                          first_prop;
    bit                          esc_pend;
    logic [3:0]                  key_idx;
    logic [1:0]                  key_live;
    target_e                     target;
    bit                          got_cmd;
    bit                          got_line;
    logic [3:0]                  cmd_idx;
    logic [1:0]                  cmd_live;
    logic [LineCountBitsDef-1:0] line_cnt;
    bit                          too_long;
    err_e                        err;
    result_t                     expected_q[$];
    int                          mismatches;

    function new();
      line_limit = MaxLineReset;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase      = PH_START;
      first_prop = 1'b1;
      esc_pend   = 1'b0;
      key_idx    = '0;
      key_live   = 2'b11;
      target     = TGT_NONE;
      got_cmd    = 1'b0;
      got_line   = 1'b0;
      cmd_idx    = '0;
      cmd_live   = 2'b11;
      line_cnt   = '0;
      too_long   = 1'b0;
      err        = ERR_NONE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Appends one word to the expected order.
    function void expect_word(result_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function bit is_blank(logic [7:0] b);
      return (b == ChSpace) || (b >= ChTab && b <= ChCr);
    endfunction

    function void fail(err_e code);
      err   = code;
      phase = PH_ERROR;
    endfunction

    function void open_key();
      key_idx  = '0;
      key_live = 2'b11;
      phase    = PH_KEY;
    endfunction

    // Both key candidates are matched in parallel; the index saturates at 15.
    function void match_key(logic [7:0] b);
      if (!(key_idx < KeyCommand.len() && b == KeyCommand[key_idx])) key_live[0] = 1'b0;
      if (!(key_idx < KeyLine.len() && b == KeyLine[key_idx])) key_live[1] = 1'b0;
      if (key_idx != 4'd15) key_idx++;
    endfunction

    function void match_cmd(logic [7:0] b);
      if (!(cmd_idx < WordSend.len() && b == WordSend[cmd_idx])) cmd_live[0] = 1'b0;
      if (!(cmd_idx < WordCaps.len() && b == WordCaps[cmd_idx])) cmd_live[1] = 1'b0;
      if (cmd_idx != 4'd15) cmd_idx++;
    endfunction

    // One byte inside a string: -1 on a bad byte, 1 on the closing quote, else 0.
    function int string_step(logic [7:0] b, output logic [7:0] dec, output bit have);
      have = 1'b0;
      dec  = '0;
      if (esc_pend) begin
        esc_pend = 1'b0;
        case (b)
          ChQuote:  dec = ChQuote;
          ChBslash: dec = ChBslash;
          ChSlash:  dec = ChSlash;
          "b":      dec = 8'h08;
          "f":      dec = 8'h0C;
          "n":      dec = 8'h0A;
          "r":      dec = ChCr;
          "t":      dec = ChTab;
          default:  return -1;
        endcase
        have = 1'b1;
        return 0;
      end
      if (b == ChQuote) return 1;
      if (b < ChSpace) return -1;
      if (b == ChBslash) begin
        esc_pend = 1'b1;
        return 0;
      end
      dec  = b;
      have = 1'b1;
      return 0;
    endfunction

    // The end word reports what the parse so far amounts to.
    function result_t verdict();
      result_t r;
      err_e    code;
      bit      is_send;
      bit      is_caps;
      r    = '0;
      code = ERR_NONE;
      case (phase)
        PH_START, PH_PLAIN: begin
          r.kind = KIND_PLAIN;
          return r;
        end
        PH_ERROR:           code = err;
        PH_OBJ:             code = first_prop ? ERR_NAME : ERR_COMMA;
        PH_COMMA, PH_KEY:   code = ERR_NAME;
        PH_COLON:           code = ERR_COLON;
        PH_PREVAL, PH_VAL:  code = ERR_VALUE;
        default: begin
          is_send = got_cmd && cmd_live[0] && cmd_idx == WordSend.len();
          is_caps = got_cmd && cmd_live[1] && cmd_idx == WordCaps.len();
          if (is_send) begin
            if (!got_line || line_cnt == 0 || too_long || line_cnt > line_limit) begin
              code = ERR_LENGTH;
            end else begin
              r.kind        = KIND_CMD;
              r.cmd         = CMD_SEND;
              r.line_length = line_cnt;
              return r;
            end
          end else if (!is_caps) begin
            code = ERR_COMMAND;
          end else if (got_line) begin
            code = ERR_CAPLINE;
          end else begin
            r.kind = KIND_CMD;
            r.cmd  = CMD_CAPS;
            return r;
          end
        end
      endcase
      r.kind     = KIND_ERROR;
      r.err_code = code;
      return r;
    endfunction

    // Advances the parse by one accepted input word and queues what it yields.
    function void note_word(logic [7:0] b, logic eot);
      result_t    r;
      logic [7:0] dec;
      bit         have;
      int         st;
      r = '0;
      if (eot) begin
        expect_word(verdict());
        clear();
        return;
      end
      case (phase)
        PH_START: begin
          if (!is_blank(b)) phase = (b == ChLbrace) ? PH_OBJ : PH_PLAIN;
        end
        PH_OBJ: begin
          if (!is_blank(b)) begin
            if (b == ChRbrace) begin
              phase = PH_TAIL;
            end else if (first_prop) begin
              if (b == ChQuote) begin
                first_prop = 1'b0;
                open_key();
              end else begin
                fail(ERR_NAME);
              end
            end else if (b == ChComma) begin
              phase = PH_COMMA;
            end else begin
              fail(ERR_COMMA);
            end
          end
        end
        PH_COMMA: begin
          if (!is_blank(b)) begin
            if (b == ChQuote) open_key();
            else fail(ERR_NAME);
          end
        end
        PH_KEY: begin
          st = string_step(b, dec, have);
          if (st < 0) fail(ERR_NAME);
          else if (st > 0) phase = PH_COLON;
          else if (have) match_key(dec);
        end
        PH_COLON: begin
          if (!is_blank(b)) begin
            if (b == ChColon) phase = PH_PREVAL;
            else fail(ERR_COLON);
          end
        end
        PH_PREVAL: begin
          if (!is_blank(b)) begin
            if (b == ChQuote) begin
              if (key_live[0] && key_idx == KeyCommand.len() && !got_cmd) target = TGT_CMD;
              else if (key_live[1] && key_idx == KeyLine.len() && !got_line) target = TGT_LINE;
              else target = TGT_NONE;
              phase = PH_VAL;
            end else begin
              fail(ERR_VALUE);
            end
          end
        end
        PH_VAL: begin
          st = string_step(b, dec, have);
          if (st < 0) begin
            fail(ERR_VALUE);
          end else if (st > 0) begin
            if (target == TGT_CMD) got_cmd = 1'b1;
            else if (target == TGT_LINE) got_line = 1'b1;
            // An unknown or repeated key shows up only once its value closes.
            if (target == TGT_NONE) fail(ERR_KEY);
            else phase = PH_OBJ;
            target = TGT_NONE;
          end else if (have) begin
            if (target == TGT_CMD) begin
              match_cmd(dec);
            end else if (target == TGT_LINE) begin
              if (line_cnt >= line_limit || line_cnt == '1) too_long = 1'b1;
              else line_cnt++;
              r.kind      = KIND_LINE;
              r.line_byte = dec;
              expect_word(r);
            end
          end
        end
        PH_TAIL: begin
          if (!is_blank(b)) fail(ERR_TRAIL);
        end
        default: ;
      endcase
    endfunction

    // Compares one popped result word with the oldest expected one.
    function void check_word(result_t got);
      result_t exp;
      bit      bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d byte %h cmd %0d err %0d len %0d",
                   got.kind, got.line_byte, got.cmd, got.err_code, got.line_length);
        return;
      end
      exp = expected_q.pop_front();
      bad = (got.kind !== exp.kind) || (got.line_byte !== exp.line_byte) ||
            (got.cmd !== exp.cmd) || (got.err_code !== exp.err_code) ||
            (got.line_length !== exp.line_length);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp kind %0d byte %h cmd %0d err %0d len %0d",
                   exp.kind, exp.line_byte, exp.cmd, exp.err_code, exp.line_length);
          $display("          got kind %0d byte %h cmd %0d err %0d len %0d",
                   got.kind, got.line_byte, got.cmd, got.err_code, got.line_length);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [7:0]          text_byte;
  logic                end_of_text;
  logic                empty;
  logic                pop;
  logic [1:0]          result_kind;
  logic [7:0]          line_byte;
  logic                command_kind;
  logic [3:0]          error_code;
  logic [LineLenW-1:0] line_length;
  logic                limit_we;
  logic [MaxLineW-1:0] limit_data;

  frame_scoreboard sb = new();
  logic [7:0]      frame_q[$];
  int              idle_pct = 7;
  bit              hold_req = 1'b0;
  int              cycles = 0;

  json_command_frame_parser DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .text_byte_i          (text_byte),
    .end_of_text_i        (end_of_text),
    .empty                (empty),
    .pop                  (pop),
    .result_kind_o        (result_kind),
    .line_byte_o          (line_byte),
    .command_kind_o       (command_kind),
    .error_code_o         (error_code),
    .line_length_o        (line_length),
    .max_line_length_we_i (limit_we),
    .max_line_length_i    (limit_data)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: checks each popped word, idles at random and holds off on request.
  initial begin
    result_t got;
    int      hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        got.kind        = kind_e'(result_kind);
        got.line_byte   = line_byte;
        got.cmd         = cmd_e'(command_kind);
        got.err_code    = error_code;
        got.line_length = line_length;
        sb.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Offers one word and waits until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic eot);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_word(b, eot);
  endtask

  // Appends one byte to the frame buffer.
  function automatic void add_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // Sends the bytes of the frame buffer followed by an end word with a random byte.
  task automatic send_frame();
    foreach (frame_q[i]) send_word(frame_q[i], 1'b0);
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    frame_q.delete();
    add_text(s);
    send_frame();
  endtask

  // Waits until every expected word is out and the block has settled, then writes the limit.
  task automatic write_limit(input logic [MaxLineW-1:0] v);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    limit_we   <= 1'b1;
    limit_data <= v;
    @(posedge clk_i);
    limit_we <= 1'b0;
    sb.line_limit = v;
  endtask

  function automatic void put_blanks();
    int n;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      case ($urandom_range(5))
        0:       add_byte(ChTab);
        1:       add_byte(8'h0A);
        2:       add_byte(8'h0B);
        3:       add_byte(8'h0C);
        4:       add_byte(ChCr);
        default: add_byte(ChSpace);
      endcase
    end
  endfunction

  function automatic void put_string(input string s);
    add_byte(ChQuote);
    add_text(s);
    add_byte(ChQuote);
  endfunction

  // A quoted value that decodes to exactly n bytes, some of them escaped.
  function automatic void put_line_value(input int n);
    logic [7:0] c;
    add_byte(ChQuote);
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        add_byte(ChBslash);
        add_byte(EscLetters[$urandom_range(7)]);
      end else begin
        c = 8'($urandom_range(8'h20, 8'hFF));
        if (c == ChQuote || c == ChBslash) c = "a";
        add_byte(c);
      end
    end
    add_byte(ChQuote);
  endfunction

  // Property codes: 0 send, 1 capabilities, 2 other command, 3 line, 4 unknown key.
  function automatic void put_prop(input int code, input int line_top);
    string k;
    string v;
    case (code)
      0, 1, 2: k = KeyCommand;
      3:       k = KeyLine;
      default: begin
        case ($urandom_range(5))
          0:       k = "cmd";
          1:       k = "lines";
          2:       k = "commands";
          3:       k = "";
          4:       k = "lin";
          default: k = "x";
        endcase
      end
    endcase
    put_blanks();
    put_string(k);
    put_blanks();
    add_byte(ChColon);
    put_blanks();
    if (code == 0) begin
      put_string(WordSend);
    end else if (code == 1) begin
      put_string(WordCaps);
    end else if (code == 2) begin
      case ($urandom_range(5))
        0:       v = "sen";
        1:       v = "sendd";
        2:       v = "capabilitie";
        3:       v = "Send";
        4:       v = "";
        default: v = "capabilitiess";
      endcase
      put_string(v);
    end else if (code == 3) begin
      put_line_value($urandom_range(0, line_top));
    end else begin
      put_line_value($urandom_range(0, 3));
    end
    put_blanks();
  endfunction

  // Builds a random message: mostly well formed, some corrupted, some noise.
  function automatic void build_frame();
    int props[$];
    int mode;
    int line_top;
    int cut;
    int n;
    frame_q.delete();
    line_top = (int'(sb.line_limit) + 2 > 24) ? 24 : int'(sb.line_limit) + 2;
    mode = $urandom_range(99);
    if (mode >= 85) begin
      n = $urandom_range(0, 12);
      if ($urandom_range(1)) add_byte(ChLbrace);
      repeat (n) add_byte(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        if ($urandom_range(1)) props = '{0, 3};
        else props = '{3, 0};
      end
      5:       props = '{1};
      6:       props = '{1, 3};
      7:       props = '{2, 3};
      8: begin
        repeat ($urandom_range(1, 3)) props.insert(props.size(), int'($urandom_range(4)));
      end
      default: begin
        if ($urandom_range(1)) props.insert(props.size(), 3);
      end
    endcase
    put_blanks();
    add_byte(ChLbrace);
    foreach (props[i]) begin
      if (i > 0) add_byte(ChComma);
      put_prop(props[i], line_top);
    end
    put_blanks();
    add_byte(ChRbrace);
    put_blanks();
    if ($urandom_range(19) == 0) add_byte("z");
    // Broken sequences: one byte replaced, inserted, or the message cut short.
    if (mode >= 70) begin
      cut = $urandom_range(0, frame_q.size() - 1);
      case ($urandom_range(2))
        0:       frame_q[cut] = 8'($urandom_range(255));
        1:       frame_q.insert(cut, 8'($urandom_range(255)));
        default: while (frame_q.size() > cut) void'(frame_q.pop_back());
      endcase
    end
  endfunction

  // Stimulus.
  initial begin
    int sent;
    int v;
    int budget;
    rst_ni      = 1'b0;
    push        = 1'b0;
    text_byte   = '0;
    end_of_text = 1'b0;
    limit_we    = 1'b0;
    limit_data  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed messages at the reset limit: plain text, commands and every error.
    send_text("");
    send_text(" \t\n ");
    send_text("hello {");
    send_text("{\"command\":\"send\",\"line\":\"hi\"}");
    send_text(" { \"command\" : \"capabilities\" } ");
    send_text("{}");
    send_text("{\"line\":\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\",\"command\":\"send\"}");
    send_text("{\"line\":\"a\\q\"}");
    send_text("{\"li\tne\":\"x\"}");
    send_text("{\"comm\\/and\":\"x\"}");
    send_text("{\"comm\\x\":\"x\"}");
    send_text("{\"command\":\"se");
    send_text("{\"command\"");
    send_text("{\"command\":");
    send_text("{");
    send_text("{\"command\":\"send\"");
    send_text("{\"command\":\"send\",");
    send_text("{\"foo\":\"x\",\"command\":\"send\"}");
    send_text("{\"line\":\"ab\",\"line\":\"cd\",\"command\":\"send\"}");
    send_text("{\"command\":\"send\",\"line\":\"x\"} z");
    send_text("{\"command\":\"capabilities\",\"line\":\"x\"}");
    send_text("{\"command\":\"send\"}");
    send_text("{\"command\":\"send\",\"line\":\"\"}");
    send_text("{\"command\":\"sendx\"}");
    send_text("{\"command\" 5");
    send_text("{\"command\":5}");
    send_text("{\"command\":\"send\"x");
    send_text("{x\"\"}");
    // Extreme byte values inside a line, then a control byte that breaks it.
    frame_q.delete();
    add_text("{\"command\":\"send\",\"line\":\"");
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(8'h7F);
    add_byte(ChQuote);
    add_byte(ChRbrace);
    send_frame();
    frame_q.delete();
    add_text("{\"line\":\"");
    add_byte(8'h00);
    add_byte(ChQuote);
    add_byte(ChRbrace);
    send_frame();

    // A line past the limit, while the result side holds off.
    write_limit(12'd40);
    frame_q.delete();
    add_text("{\"command\":\"send\",\"line\":");
    put_line_value(45);
    add_byte(ChRbrace);
    hold_req = 1'b1;
    send_frame();

    // Smallest limit: one byte fits, two do not.
    write_limit(12'd1);
    send_text("{\"command\":\"send\",\"line\":\"a\"}");
    send_text("{\"command\":\"send\",\"line\":\"ab\"}");

    // Random messages under several limits; one longer phase runs without idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       v = 1;
        1:       v = 4095;
        2:       v = 5;
        3:       v = $urandom_range(2, 40);
        default: v = 511;
      endcase
      write_limit(MaxLineW'(v));
      idle_pct = (ph == 2) ? 0 : 7;
      budget   = (ph == 2) ? 150 : 50;
      sent = 0;
      while (sent < budget) begin
        build_frame();
        sent += frame_q.size() + 1;
        send_frame();
      end
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== json_command_frame_parser.f =====
rtl/jcfp_pkg.sv
rtl/jcfp_fifo.sv
rtl/jcfp_front.sv
rtl/jcfp_back.sv
rtl/json_command_frame_parser.sv
dv/json_command_frame_parser_tb.sv
